### src/mssr_pkg.sv
// shared constants, types and register codes of the minimum-separation step reducer
package mssr_pkg;

	// sizes of the position store and the reduction search
	localparam int MAX_PARTICLES  = 1024;
	localparam int MAX_REDUCTIONS = 15;
	localparam int IDX_W          = $clog2(MAX_PARTICLES);
	localparam int CNT_W          = $clog2(MAX_PARTICLES + 1);
	localparam int NUM_CELLS      = MAX_REDUCTIONS + 1;

	// field widths
	localparam int POS_W  = 32;
	localparam int DATA_W = 32;
	localparam int SQ_W   = 2 * DATA_W;
	localparam int K_W    = 4;

	localparam logic [K_W-1:0] K_MAX = K_W'(MAX_REDUCTIONS);

	// floor(x / 10) for a 32-bit x is (x * RECIP10) >> RECIP_SHIFT
	localparam logic [DATA_W-1:0] RECIP10     = 32'hCCCC_CCCD;
	localparam int                RECIP_SHIFT = 35;

	// configuration port
	localparam int APB_AW      = 3;
	localparam int REG_IDX_LSB = 2;
	localparam int APB_DW      = 32;

	typedef logic [APB_AW-1:REG_IDX_LSB] reg_idx_t;
	localparam reg_idx_t REG_BASE_DIST = 1'd0;
	localparam reg_idx_t REG_INIT_STEP = 1'd1;

	localparam logic [DATA_W-1:0] BASE_DIST_RST = 32'd1678;
	localparam logic [DATA_W-1:0] INIT_STEP_RST = 32'd1000;

	typedef logic signed [POS_W-1:0] pos_t;

	// one slot of the reduction chain
	typedef struct packed {
		logic              valid;
		logic [SQ_W-1:0]   min_sq;
		logic [DATA_W-1:0] thr;
		logic [DATA_W-1:0] step;
		logic [K_W-1:0]    k;
		logic              done;
		logic              sat;
	} cell_t;

	// control from the sequencer to the pair scanner
	typedef struct packed {
		logic start;
		logic clear;
	} scan_ctl_t;

	// status from the pair scanner
	typedef struct packed {
		logic            busy;
		logic [SQ_W-1:0] min_sq;
	} scan_sts_t;

endpackage

### src/mssr_in_if.sv
// particle position channel
interface mssr_in_if;
	import mssr_pkg::*;

	logic valid;
	logic ready;
	pos_t pos_x;
	pos_t pos_y;
	logic last_particle;

	modport source (output valid, output pos_x, output pos_y, output last_particle,
		input ready);
	modport sink (input valid, input pos_x, input pos_y, input last_particle,
		output ready);
endinterface

### src/mssr_out_if.sv
// reduced time step result channel
interface mssr_out_if;
	import mssr_pkg::*;

	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] step_out;
	logic [K_W-1:0]    reductions;
	logic              reduction_saturated;

	modport source (output valid, output step_out, output reductions,
		output reduction_saturated, input ready);
	modport sink (input valid, input step_out, input reductions,
		input reduction_saturated, output ready);
endinterface

### src/mssr_scan.sv
// position store and pipelined pairwise squared-separation scan with running minimum
module mssr_scan (
	input  logic                clk,
	input  logic                arst_n,
	input  mssr_pkg::scan_ctl_t ctl,
	input  mssr_pkg::pos_t      pos_x,
	input  mssr_pkg::pos_t      pos_y,
	output mssr_pkg::scan_sts_t sts
);
	import mssr_pkg::*;

	logic [POS_W-1:0] x_mem [MAX_PARTICLES];
	logic [POS_W-1:0] y_mem [MAX_PARTICLES];

	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] rd_cnt_q;
	logic             sweep_q;
	logic [SQ_W-1:0]  min_q;
	pos_t             px_q;
	pos_t             py_q;
	logic             store_en;

	logic             v_s1, v_s2, v_s3, v_s4;
	pos_t             rdx_s1, rdy_s1;
	logic [POS_W-1:0] dx_s2, dy_s2;
	logic [SQ_W-1:0]  sqx_s3, sqy_s3;
	logic [SQ_W-1:0]  sep_s4;

	logic [POS_W:0]   dfx, dfy, ngx, ngy;
	logic [POS_W-1:0] magx, magy;
	logic [SQ_W:0]    sum;

	assign store_en = ctl.start && (cnt_q != CNT_W'(MAX_PARTICLES));

	// sequencing of the read sweep, fill count and running minimum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			n_q      <= '0;
			rd_cnt_q <= '0;
			sweep_q  <= 1'b0;
			min_q    <= '1;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
		end else begin
			v_s1 <= sweep_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (ctl.clear) begin
				cnt_q <= '0;
				min_q <= '1;
			end else begin
				if (store_en) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
				if (v_s4 && (sep_s4 < min_q)) begin
					min_q <= sep_s4;
				end
			end
			if (ctl.start) begin
				rd_cnt_q <= '0;
				n_q      <= cnt_q;
				sweep_q  <= (cnt_q != '0);
			end else if (sweep_q) begin
				rd_cnt_q <= rd_cnt_q + CNT_W'(1);
				if ((rd_cnt_q + CNT_W'(1)) == n_q) begin
					sweep_q <= 1'b0;
				end
			end
		end
	end

	// position memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (store_en) begin
			x_mem[cnt_q[IDX_W-1:0]] <= pos_x;
			y_mem[cnt_q[IDX_W-1:0]] <= pos_y;
		end
		rdx_s1 <= x_mem[rd_cnt_q[IDX_W-1:0]];
		rdy_s1 <= y_mem[rd_cnt_q[IDX_W-1:0]];
	end

	// capture the new position for the whole sweep
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			px_q <= pos_x;
			py_q <= pos_y;
		end
	end

	// absolute coordinate differences
	assign dfx  = {px_q[POS_W-1], px_q} - {rdx_s1[POS_W-1], rdx_s1};
	assign dfy  = {py_q[POS_W-1], py_q} - {rdy_s1[POS_W-1], rdy_s1};
	assign ngx  = -dfx;
	assign ngy  = -dfy;
	assign magx = dfx[POS_W] ? ngx[POS_W-1:0] : dfx[POS_W-1:0];
	assign magy = dfy[POS_W] ? ngy[POS_W-1:0] : dfy[POS_W-1:0];

	// saturating sum of squares
	assign sum = {1'b0, sqx_s3} + {1'b0, sqy_s3};

	// difference, square and sum stages
	always_ff @(posedge clk) begin
		dx_s2  <= magx;
		dy_s2  <= magy;
		sqx_s3 <= SQ_W'(dx_s2) * SQ_W'(dx_s2);
		sqy_s3 <= SQ_W'(dy_s2) * SQ_W'(dy_s2);
		sep_s4 <= sum[SQ_W] ? '1 : sum[SQ_W-1:0];
	end

	assign sts.busy   = sweep_q | v_s1 | v_s2 | v_s3 | v_s4;
	assign sts.min_sq = min_q;

`ifndef ASSERT_OFF
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |-> !sts.busy)
		else $error("new position arrived while a scan was in flight");
	a_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clear |-> !sts.busy)
		else $error("cloud cleared while a scan was in flight");
	a_sweep_range: assert property (@(posedge clk) disable iff (!arst_n)
		sweep_q |-> (rd_cnt_q < n_q))
		else $error("read sweep ran past the stored positions");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_PARTICLES))
		else $error("fill count beyond store depth");
`endif

endmodule

### src/mssr_cell.sv
// one cell of the tenfold reduction chain: threshold test and divide by ten
module mssr_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  mssr_pkg::cell_t prev,
	output mssr_pkg::cell_t next
);
	import mssr_pkg::*;

	logic              valid_q;
	cell_t             pay_q;
	cell_t             nxt;
	logic [SQ_W-1:0]   sq;
	logic [SQ_W-1:0]   thr_prod;
	logic [SQ_W-1:0]   step_prod;
	logic              too_close;

	// threshold square and reciprocal products side by side
	assign sq        = SQ_W'(prev.thr) * SQ_W'(prev.thr);
	assign thr_prod  = SQ_W'(prev.thr) * SQ_W'(RECIP10);
	assign step_prod = SQ_W'(prev.step) * SQ_W'(RECIP10);
	assign too_close = (prev.min_sq <= sq);

	// one search step
	always_comb begin
		nxt = prev;
		if (!prev.done) begin
			if (!too_close) begin
				nxt.done = 1'b1;
			end else if (prev.k == K_MAX) begin
				nxt.sat  = 1'b1;
				nxt.done = 1'b1;
			end else begin
				nxt.thr  = DATA_W'(thr_prod >> RECIP_SHIFT);
				nxt.step = DATA_W'(step_prod >> RECIP_SHIFT);
				nxt.k    = prev.k + K_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= prev.valid;
		end
	end

	always_ff @(posedge clk) begin
		pay_q <= nxt;
	end

	always_comb begin
		next       = pay_q;
		next.valid = valid_q;
	end

endmodule

### src/min_separation_step_reducer_top.sv
// top level of the minimum-separation step reducer
//
//   channel    dir  handshake          transaction
//   particle   in   valid/ready        pos_x, pos_y, last_particle
//   result     out  valid/ready        step_out, reductions, reduction_saturated
//   apb        in   psel/penable/pwr   base_dist @0x0, init_step @0x4
//
// a position is compared with each position already stored: the single read port of the
// position memory feeds the four-stage separation pipe once a cycle. a last position then
// passes the launch state and the 16-cell reduction chain. reset needs no clearing pass;
// the store is read only below its fill count.
// the result register holds while result.ready is low; positions keep flowing, and
// the next last position waits for the register to empty before reducing.
module min_separation_step_reducer_top (
	input  logic                          clk,
	input  logic                          arst_n,
	mssr_in_if.sink                       particle,
	mssr_out_if.source                    result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mssr_pkg::APB_AW-1:0]   paddr,
	input  logic [mssr_pkg::APB_DW-1:0]   pwdata,
	output logic [mssr_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);
	import mssr_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LAUNCH,
		ST_REDUCE
	} state_t;

	state_t            state_q;
	logic              last_q;
	logic              out_valid_q;
	logic [DATA_W-1:0] step_q;
	logic [K_W-1:0]    k_q;
	logic              sat_q;
	logic [DATA_W-1:0] base_dist_q;
	logic [DATA_W-1:0] init_step_q;

	logic              accept;
	logic              launch;
	logic              wr_en;
	reg_idx_t          reg_idx;
	scan_ctl_t         ctl;
	scan_sts_t         sts;
	cell_t             chain [NUM_CELLS+1];
	cell_t             chain_end;

	// configuration registers
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[APB_AW-1:REG_IDX_LSB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_dist_q <= BASE_DIST_RST;
			init_step_q <= INIT_STEP_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_BASE_DIST: base_dist_q <= pwdata;
				REG_INIT_STEP: init_step_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_BASE_DIST: prdata = base_dist_q;
			REG_INIT_STEP: prdata = init_step_q;
			default: prdata = '0;
		endcase
	end

	// handshakes and scanner control
	assign particle.ready = (state_q == ST_IDLE);
	assign accept         = particle.valid && particle.ready;
	assign launch         = (state_q == ST_LAUNCH) && !out_valid_q;
	assign ctl.start      = accept;
	assign ctl.clear      = launch;

	mssr_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.pos_x  (particle.pos_x),
		.pos_y  (particle.pos_y),
		.sts    (sts)
	);

	// head of the reduction chain
	always_comb begin
		chain[0].valid  = launch;
		chain[0].min_sq = sts.min_sq;
		chain[0].thr    = base_dist_q;
		chain[0].step   = init_step_q;
		chain[0].k      = '0;
		chain[0].done   = 1'b0;
		chain[0].sat    = 1'b0;
	end

	for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
		mssr_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.prev   (chain[c]),
			.next   (chain[c+1])
		);
	end

	assign chain_end = chain[NUM_CELLS];

	// sequencer and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						last_q  <= particle.last_particle;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (!sts.busy) begin
						state_q <= last_q ? ST_LAUNCH : ST_IDLE;
					end
				end
				ST_LAUNCH: begin
					if (!out_valid_q) begin
						state_q <= ST_REDUCE;
					end
				end
				ST_REDUCE: begin
					if (chain_end.valid) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (chain_end.valid) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload register
	always_ff @(posedge clk) begin
		if (chain_end.valid) begin
			step_q <= chain_end.step;
			k_q    <= chain_end.k;
			sat_q  <= chain_end.sat;
		end
	end

	assign result.valid               = out_valid_q;
	assign result.step_out            = step_q;
	assign result.reductions          = k_q;
	assign result.reduction_saturated = sat_q;

`ifndef ASSERT_OFF
	a_land_free: assert property (@(posedge clk) disable iff (!arst_n)
		chain_end.valid |-> !out_valid_q)
		else $error("reduction result landed on a full result register");
	a_land_state: assert property (@(posedge clk) disable iff (!arst_n)
		chain_end.valid |-> (state_q == ST_REDUCE))
		else $error("reduction result outside the reduce phase");
	a_sat_k: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.reduction_saturated) |-> (result.reductions == K_MAX))
		else $error("saturation flagged below the reduction limit");
`endif

endmodule

### bench/min_separation_step_reducer_top_tb.sv
// self-checking testbench of the minimum-separation step reducer top level
`timescale 1ns / 1ps

module min_separation_step_reducer_top_tb;
	import mssr_pkg::*;

	localparam int   NUM_DIRECTED = 23;
	localparam int   SMALL_ITEMS = 80;
	localparam int   SETTLE_CYCLES = 40;
	localparam int   DRAIN_CYCLES = 64;
	localparam pos_t POS_MIN = 32'sh8000_0000;
	localparam pos_t POS_MAX = 32'sh7FFF_FFFF;

	// one reduced time step as it leaves the block
	typedef struct packed {
		logic [DATA_W-1:0] step;
		logic [K_W-1:0]    k;
		logic              sat;
	} step_result_t;

	// one row of the directed table: a register write or a position
	typedef struct packed {
		logic              cfg_row;
		reg_idx_t          reg_sel;
		logic [DATA_W-1:0] reg_val;
		pos_t              x;
		pos_t              y;
		logic              last_particle;
		logic              typed;
		step_result_t      want;
	} stim_row_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [APB_AW-1:0]   paddr;
	logic [APB_DW-1:0]   pwdata;
	logic [APB_DW-1:0]   prdata;
	logic                pready;

	mssr_in_if  particle_ch();
	mssr_out_if result_ch();

	min_separation_step_reducer_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.particle (particle_ch),
		.result   (result_ch),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// predictor state: stored cloud, closest pair and register copies
	pos_t              stored_x [MAX_PARTICLES];
	pos_t              stored_y [MAX_PARTICLES];
	int unsigned       stored_count = 0;
	logic [SQ_W-1:0]   closest_sq = '1;
	logic [DATA_W-1:0] cfg_base_dist = BASE_DIST_RST;
	logic [DATA_W-1:0] cfg_init_step = INIT_STEP_RST;

	step_result_t pending_steps [$];
	int unsigned  mismatches = 0;
	bit           quiet = 0;
	stim_row_t    directed_rows [NUM_DIRECTED];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#30ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	// squared separation of two positions, saturating at the 64-bit maximum
	function automatic logic [SQ_W-1:0] pair_sq(pos_t ax, pos_t ay, pos_t bx, pos_t by);
		longint          dxs;
		longint          dys;
		logic [SQ_W-1:0] sx;
		logic [SQ_W-1:0] sy;
		logic [SQ_W:0]   total;
		dxs = longint'(ax) - longint'(bx);
		dys = longint'(ay) - longint'(by);
		if (dxs < 0) dxs = -dxs;
		if (dys < 0) dys = -dys;
		sx = SQ_W'(dxs) * SQ_W'(dxs);
		sy = SQ_W'(dys) * SQ_W'(dys);
		total = {1'b0, sx} + {1'b0, sy};
		return total[SQ_W] ? '1 : total[SQ_W-1:0];
	endfunction

	// fold one accepted position into the cloud; on the last one reduce the step
	function automatic bit absorb_position(pos_t x, pos_t y, logic lst,
			output step_result_t res);
		logic [SQ_W-1:0] d;
		logic [SQ_W-1:0] thr;
		logic [SQ_W-1:0] stp;
		int unsigned     k;
		bit              sat;
		res = '0;
		for (int i = 0; i < stored_count; i++) begin
			d = pair_sq(x, y, stored_x[i], stored_y[i]);
			if (d < closest_sq) closest_sq = d;
		end
		// a full store still compares but keeps nothing new
		if (stored_count < MAX_PARTICLES) begin
			stored_x[stored_count] = x;
			stored_y[stored_count] = y;
			stored_count++;
		end
		if (!lst) return 0;
		thr = cfg_base_dist;
		stp = cfg_init_step;
		k = 0;
		sat = 0;
		// tenfold reductions until the closest pair clears the threshold or the limit is reached
		while (!sat && closest_sq <= thr * thr) begin
			if (k >= MAX_REDUCTIONS) begin
				sat = 1;
			end else begin
				thr = thr / 10;
				stp = stp / 10;
				k++;
			end
		end
		res.step = stp[DATA_W-1:0];
		res.k = K_W'(k);
		res.sat = sat;
		stored_count = 0;
		closest_sq = '1;
		return 1;
	endfunction

	function automatic stim_row_t pos_row(pos_t x, pos_t y, logic lst);
		stim_row_t row;
		row = '0;
		row.x = x;
		row.y = y;
		row.last_particle = lst;
		return row;
	endfunction

	function automatic stim_row_t known_row(pos_t x, pos_t y, logic [DATA_W-1:0] step,
			logic [K_W-1:0] k, logic sat);
		stim_row_t row;
		row = pos_row(x, y, 1'b1);
		row.typed = 1'b1;
		row.want.step = step;
		row.want.k = k;
		row.want.sat = sat;
		return row;
	endfunction

	function automatic stim_row_t cfg_row(reg_idx_t sel, logic [DATA_W-1:0] val);
		stim_row_t row;
		row = '0;
		row.cfg_row = 1'b1;
		row.reg_sel = sel;
		row.reg_val = val;
		return row;
	endfunction

	// register values: extremes, reset value or a random magnitude
	function automatic logic [DATA_W-1:0] pick_reg_value(logic [DATA_W-1:0] rst_val);
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return rst_val;
			default: return $urandom >> $urandom_range(0, 31);
		endcase
	endfunction

	// signed offset of up to span_bits bits
	function automatic pos_t jitter(int unsigned span_bits);
		logic [DATA_W-1:0] mag;
		mag = DATA_W'($urandom & ((64'd1 << span_bits) - 64'd1));
		return $urandom_range(0, 1) ? -pos_t'(mag) : pos_t'(mag);
	endfunction

	// offer one position transaction and predict once it is taken
	task automatic offer_position(pos_t x, pos_t y, logic lst, logic typed,
			step_result_t want);
		step_result_t got;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			particle_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		particle_ch.valid <= 1'b1;
		particle_ch.pos_x <= x;
		particle_ch.pos_y <= y;
		particle_ch.last_particle <= lst;
		do @(posedge clk); while (!particle_ch.ready);
		if (absorb_position(x, y, lst, got))
			pending_steps.push_back(typed ? want : got);
	endtask

	// stop sending and let the block drain before touching registers
	task automatic quiesce();
		particle_ch.valid <= 1'b0;
		while (pending_steps.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// apb write: setup cycle, then access cycle until pready
	task automatic write_reg(reg_idx_t sel, logic [DATA_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (sel)
			REG_BASE_DIST: cfg_base_dist = val;
			REG_INIT_STEP: cfg_init_step = val;
			default: ;
		endcase
		// read back the register once the write has landed
		@(posedge clk);
		if (prdata !== val) begin
			$error("prdata: expected %0h, got %0h", val, prdata);
			mismatches++;
		end
	endtask

	// one cloud around a random center, with stray and repeated positions
	task automatic send_cloud(int unsigned size);
		pos_t        cx;
		pos_t        cy;
		pos_t        px;
		pos_t        py;
		int unsigned spread;
		cx = $urandom;
		cy = $urandom;
		spread = $urandom_range(0, 31);
		px = cx;
		py = cy;
		for (int i = 0; i < size; i++) begin
			case ($urandom_range(0, 9))
				0: ;
				1: begin
					px = $urandom;
					py = $urandom;
				end
				default: begin
					px = cx + jitter(spread);
					py = cy + jitter(spread);
				end
			endcase
			offer_position(px, py, i == size - 1, 1'b0, '0);
		end
	endtask

	// result side back-pressure in bursts
	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			if (!quiet && $urandom_range(0, 4) == 0) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end else begin
				result_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end
		end
	end

	// compare each result transaction with the oldest predicted step
	always @(posedge clk) begin : result_check
		step_result_t want;
		if (result_ch.valid && result_ch.ready) begin
			if (pending_steps.size() == 0) begin
				$error("unexpected result: step_out %0d reductions %0d saturated %0d",
					result_ch.step_out, result_ch.reductions, result_ch.reduction_saturated);
				mismatches++;
			end else begin
				want = pending_steps.pop_front();
				if (result_ch.step_out !== want.step) begin
					$error("step_out: expected %0d, got %0d", want.step, result_ch.step_out);
					mismatches++;
				end
				if (result_ch.reductions !== want.k) begin
					$error("reductions: expected %0d, got %0d", want.k, result_ch.reductions);
					mismatches++;
				end
				if (result_ch.reduction_saturated !== want.sat) begin
					$error("reduction_saturated: expected %0d, got %0d", want.sat,
						result_ch.reduction_saturated);
					mismatches++;
				end
			end
		end
	end

	initial begin : stimulus
		int unsigned random_items;
		int unsigned cloud_size;
		bit          full_done;
		random_items = 0;
		full_done = 0;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		particle_ch.valid <= 1'b0;
		particle_ch.pos_x <= '0;
		particle_ch.pos_y <= '0;
		particle_ch.last_particle <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table: lone particle, coincident pair, overflow, register extremes
		directed_rows = '{
			known_row(0, 0, 32'd1000, K_W'(0), 1'b0),
			pos_row(5, 5, 1'b0),
			known_row(5, 5, 32'd0, K_MAX, 1'b1),
			pos_row(POS_MIN, POS_MIN, 1'b0),
			known_row(POS_MAX, POS_MAX, 32'd1000, K_W'(0), 1'b0),
			pos_row(0, 0, 1'b0),
			pos_row(1000, 0, 1'b0),
			pos_row(0, -2000, 1'b1),
			pos_row(POS_MAX, POS_MIN, 1'b0),
			pos_row(-1, 0, 1'b0),
			pos_row(32'sh00AB_CDEF, 32'shFF12_3456, 1'b1),
			cfg_row(REG_BASE_DIST, 32'd0),
			cfg_row(REG_INIT_STEP, 32'hFFFF_FFFF),
			known_row(7, -7, 32'hFFFF_FFFF, K_W'(0), 1'b0),
			pos_row(-3, 9, 1'b0),
			known_row(-3, 9, 32'd0, K_MAX, 1'b1),
			pos_row(1, 1, 1'b0),
			pos_row(1, 2, 1'b1),
			cfg_row(REG_BASE_DIST, 32'hFFFF_FFFF),
			cfg_row(REG_INIT_STEP, 32'd0),
			pos_row(POS_MIN, 0, 1'b0),
			pos_row(POS_MAX, 0, 1'b1),
			known_row(POS_MAX, 32'sh5555_5555, 32'd0, K_W'(0), 1'b0)
		};
		for (int r = 0; r < NUM_DIRECTED; r++) begin
			if (directed_rows[r].cfg_row) begin
				quiesce();
				write_reg(directed_rows[r].reg_sel, directed_rows[r].reg_val);
			end else begin
				offer_position(directed_rows[r].x, directed_rows[r].y,
					directed_rows[r].last_particle, directed_rows[r].typed,
					directed_rows[r].want);
			end
		end

		// random phases: new register settings, then a few clouds
		while (!full_done) begin
			quiesce();
			if ($urandom_range(0, 3) != 0)
				write_reg(REG_BASE_DIST, pick_reg_value(BASE_DIST_RST));
			if ($urandom_range(0, 3) != 0)
				write_reg(REG_INIT_STEP, pick_reg_value(INIT_STEP_RST));
			if (random_items >= SMALL_ITEMS) begin
				// last phase with no idling: one cloud that overflows the store
				quiet = 1;
				send_cloud(MAX_PARTICLES + $urandom_range(1, 6));
				full_done = 1;
			end else begin
				for (int c = $urandom_range(1, 5); c > 0; c--) begin
					case ($urandom_range(0, 19))
						0: cloud_size = 1;
						1: cloud_size = $urandom_range(30, 60);
						default: cloud_size = $urandom_range(2, 12);
					endcase
					send_cloud(cloud_size);
					random_items += cloud_size;
				end
			end
		end

		// drain and report
		particle_ch.valid <= 1'b0;
		while (pending_steps.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
